/* rtl/deferred_delete_tracker_core_macros.svh */
// Assertion macros shared by the tracker RTL. Each check is sampled on
// clk_i and is disabled while rst_ni is low.
`ifndef DEFERRED_DELETE_TRACKER_CORE_MACROS_SVH
`define DEFERRED_DELETE_TRACKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DDT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define DDT_ASSERT(lbl, prop, msg)
`define DDT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/ddt_pkg.sv */
package ddt_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned IdW      = 32;
  localparam int unsigned AgeW     = 8;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_START = 2'd2,
    REQ_TRACK = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_STARTED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE = 4'b0001,
    FSM_READ = 4'b0010,
    FSM_EVAL = 4'b0100,
    FSM_FIN  = 4'b1000
  } fsm_e;

  typedef struct packed {
    logic [1:0]     req_type;
    logic [IdW-1:0] item_id;
  } req_t;

  typedef struct packed {
    logic [1:0]     status;
    logic           item_dead;
    logic [IdW-1:0] reclaimed_id;
    logic           reclaimed_valid;
    logic           last;
  } rsp_t;

  // One memory word: identifier and merge age of a slot.
  typedef struct packed {
    logic [IdW-1:0]  ident;
    logic [AgeW-1:0] age;
  } ent_t;

endpackage

/* rtl/ddt_mem.sv */
module ddt_mem (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [ddt_pkg::IdxW-1:0] waddr_i,
  input  ddt_pkg::ent_t            wdata_i,
  input  logic                     re_i,
  input  logic [ddt_pkg::IdxW-1:0] raddr_i,
  output ddt_pkg::ent_t            rdata_o
);

  ddt_pkg::ent_t mem_q [ddt_pkg::Capacity];
  ddt_pkg::ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/deferred_delete_tracker_core.sv */
// Deferred delete tracker. The table of deleted identifiers lives in a
// one-port-write, one-port-read memory of Capacity words, each holding an
// identifier and its merge age; the valid and mark bits sit in flip-flops.
// Every request except merge start walks the memory slot by slot, each slot
// in a read state and then an evaluate-and-write-back state. Add and query
// stop early on a match; track merge always visits every slot and may wait
// while the output register is occupied. Merge start goes straight to the
// finish state. Track emits one beat per reclaimed identifier in ascending
// slot order, the final one with last set, or a single empty beat when
// nothing is reclaimed. A new request is taken only when the previous one
// has finished; its final beat may still wait in the output register.
`include "deferred_delete_tracker_core_macros.svh"

module deferred_delete_tracker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ddt_pkg::AgeW-1:0]       cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ddt_pkg::req_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ddt_pkg::rsp_t                  out_data_o
);

  localparam logic [ddt_pkg::IdxW-1:0] LastIdx = ddt_pkg::IdxW'(ddt_pkg::Capacity - 1);

  ddt_pkg::fsm_e                  state_q, state_d;
  logic [ddt_pkg::AgeW-1:0]       limit_q;
  ddt_pkg::req_t                  req_q;
  logic [ddt_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [ddt_pkg::Capacity-1:0]   valid_q, valid_d;
  logic [ddt_pkg::Capacity-1:0]   mark_q, mark_d;
  logic                           pending_q, pending_d;
  logic                           free_found_q, free_found_d;
  logic [ddt_pkg::IdxW-1:0]       free_idx_q, free_idx_d;
  logic                           hold_valid_q, hold_valid_d;
  logic [ddt_pkg::IdW-1:0]        hold_id_q, hold_id_d;
  ddt_pkg::rsp_t                  res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  ddt_pkg::rsp_t                  out_q, out_d;

  logic                           mem_we, mem_re;
  logic [ddt_pkg::IdxW-1:0]       mem_waddr;
  ddt_pkg::ent_t                  mem_wdata, mem_rdata;

  logic                           out_free;
  logic                           in_acc;
  logic                           slot_valid, slot_hit, slot_reclaim;
  logic [ddt_pkg::AgeW-1:0]       new_age;
  ddt_pkg::rsp_t                  empty_rsp;

  ddt_mem u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(idx_q),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o  = (state_q == ddt_pkg::FSM_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Per-slot evaluation of the word read in the READ state.
  assign slot_valid   = valid_q[idx_q];
  assign slot_hit     = slot_valid && (mem_rdata.ident == req_q.item_id);
  assign new_age      = (mark_q[idx_q] && (mem_rdata.age != '1)) ?
                        mem_rdata.age + ddt_pkg::AgeW'(1) : mem_rdata.age;
  assign slot_reclaim = slot_valid && (new_age >= limit_q);

  always_comb begin
    empty_rsp        = '0;
    empty_rsp.last   = 1'b1;

    state_d      = state_q;
    idx_d        = idx_q;
    valid_d      = valid_q;
    mark_d       = mark_q;
    pending_d    = pending_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    hold_valid_d = hold_valid_q;
    hold_id_d    = hold_id_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;

    unique case (state_q)
      ddt_pkg::FSM_IDLE: begin
        if (in_acc) begin
          idx_d        = '0;
          free_found_d = 1'b0;
          hold_valid_d = 1'b0;
          res_d        = empty_rsp;
          if (in_data_i.req_type == ddt_pkg::REQ_START) begin
            // Marking is a single flop-wide copy of the valid bits.
            if (pending_q) begin
              res_d.status = ddt_pkg::ST_STARTED;
            end else begin
              mark_d    = valid_q;
              pending_d = 1'b1;
            end
            state_d = ddt_pkg::FSM_FIN;
          end else begin
            state_d = ddt_pkg::FSM_READ;
          end
        end
      end

      ddt_pkg::FSM_READ: begin
        mem_re  = 1'b1;
        state_d = ddt_pkg::FSM_EVAL;
      end

      ddt_pkg::FSM_EVAL: begin
        if (req_q.req_type == ddt_pkg::REQ_TRACK) begin
          // A reclaimed slot pushes the previously held identifier out as a
          // non-final beat; wait here if that beat finds the output register occupied.
          if (!(slot_reclaim && hold_valid_q && !out_free)) begin
            mark_d[idx_q] = 1'b0;
            if (slot_valid) begin
              mem_we          = 1'b1;
              mem_wdata.ident = mem_rdata.ident;
              mem_wdata.age   = new_age;
            end
            if (slot_reclaim) begin
              valid_d[idx_q] = 1'b0;
              if (hold_valid_q) begin
                out_valid_d                = 1'b1;
                out_d                      = '0;
                out_d.reclaimed_id         = hold_id_q;
                out_d.reclaimed_valid      = 1'b1;
              end
              hold_valid_d = 1'b1;
              hold_id_d    = mem_rdata.ident;
            end
            if (idx_q == LastIdx) begin
              res_d = empty_rsp;
              if (slot_reclaim || hold_valid_q) begin
                res_d.reclaimed_valid = 1'b1;
                res_d.reclaimed_id    = slot_reclaim ? mem_rdata.ident : hold_id_q;
              end
              pending_d = 1'b0;
              state_d   = ddt_pkg::FSM_FIN;
            end else begin
              idx_d   = idx_q + ddt_pkg::IdxW'(1);
              state_d = ddt_pkg::FSM_READ;
            end
          end
        end else begin
          if (!slot_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
          if (slot_hit || (idx_q == LastIdx)) begin
            res_d = empty_rsp;
            if (req_q.req_type == ddt_pkg::REQ_QUERY) begin
              res_d.item_dead = slot_hit;
            end else if (slot_hit) begin
              res_d.status = ddt_pkg::ST_PRESENT;
            end else if (free_found_q || !slot_valid) begin
              // Lowest free slot seen during the scan takes the new entry.
              mem_we          = 1'b1;
              mem_waddr       = free_found_q ? free_idx_q : idx_q;
              mem_wdata.ident = req_q.item_id;
              mem_wdata.age   = '0;
              valid_d[mem_waddr] = 1'b1;
              mark_d[mem_waddr]  = 1'b0;
            end else begin
              res_d.status = ddt_pkg::ST_FULL;
            end
            state_d = ddt_pkg::FSM_FIN;
          end else begin
            idx_d   = idx_q + ddt_pkg::IdxW'(1);
            state_d = ddt_pkg::FSM_READ;
          end
        end
      end

      ddt_pkg::FSM_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ddt_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_d = ddt_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ddt_pkg::FSM_IDLE;
      limit_q      <= ddt_pkg::AgeW'(1);
      valid_q      <= '0;
      mark_q       <= '0;
      pending_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
      free_found_q <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      valid_q      <= valid_d;
      mark_q       <= mark_d;
      pending_q    <= pending_d;
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
      free_found_q <= free_found_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    free_idx_q <= free_idx_d;
    hold_id_q  <= hold_id_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  `DDT_ASSERT_NEVER(a_mark_only_valid, ((mark_q & ~valid_q) != '0), "mark set on a free slot")
  `DDT_ASSERT(a_mark_needs_pending, (mark_q != '0) |-> pending_q, "marks without a merge")
  `DDT_ASSERT(a_hold_in_track, hold_valid_q |-> (req_q.req_type == ddt_pkg::REQ_TRACK), "held id outside track")

endmodule
